@@ rtl/core/tt_pkg.sv @@
// Shared definitions for the text tokenizer: character codes, token classes,
// scanner modes and the result beat and result row types. No dependencies.

package tt_pkg;

   // Default longest token, in bytes.
   localparam int MAX_TOKEN_LEN_DEF = 63;

   // Character codes used by the scanner.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_AT     = 8'h40;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_GRAVE  = 8'h60;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_TILDE  = 8'h7E;

   // Token class codes.
   localparam logic [1:0] CLASS_NUMBER = 2'd0;
   localparam logic [1:0] CLASS_STRING = 2'd1;
   localparam logic [1:0] CLASS_PUNCT  = 2'd2;
   localparam logic [1:0] CLASS_WORD   = 2'd3;

   // Scanner modes, one-hot.
   typedef enum logic [7:0] {
      MODE_IDLE   = 8'b0000_0001,
      MODE_NUMBER = 8'b0000_0010,
      MODE_WORD   = 8'b0000_0100,
      MODE_STRING = 8'b0000_1000,
      MODE_ESCAPE = 8'b0001_0000,
      MODE_MINUS  = 8'b0010_0000,
      MODE_CMP    = 8'b0100_0000,
      MODE_SKIP   = 8'b1000_0000
   } scan_mode_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic [1:0] token_class;
      logic       first_of_token;
      logic       last_of_token;
      logic       last_of_step;
   } rsp_item_type;

   // All results of one input byte: one or two beats.
   typedef struct packed {
      rsp_item_type [1:0] item;
      logic               two;
   } rsp_row_type;

endpackage

@@ rtl/core/text_tokenizer.sv @@
// Text tokenizer top level: input register, scanner and result queue.
// Depends on tt_pkg, tt_scan and tt_outq.

// The tokenizer takes one source byte per beat (or an end mark, tuser high or
// a zero byte) and sends out the characters of each token, one per beat,
// tagged with the token class (number, quoted string, punctuation, word),
// a first-of-token flag, tlast on the last byte of a token, and a flag on the
// last beat caused by each input byte. An empty quoted string gives one beat
// with byte_valid low. Because the end of a token is only known from the next
// byte, each number, word or string byte not hit by the length cut leaves one
// input byte later than it arrives. A byte enters in every cycle while the
// result queue has room; the result port moves one beat per cycle while
// rsp_tready is high, so under steady traffic each byte that yields two beats
// (a two-byte compare pair, a token end followed by a one-byte punctuation
// token, or a byte that hits the length cut) slows the input, while the two-row
// result queue absorbs an isolated one. With an empty queue, the row of a taken
// byte goes straight to the head slot. Tokens are cut at MAX_TOKEN_LEN bytes.

module text_tokenizer #(
   parameter int MAX_TOKEN_LEN = tt_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_byte, [8] first_of_token,
                                    // [9] last_of_step, [15:10] zero
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [2:1] token_class
   output logic        rsp_tlast    // last_of_token
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;
   logic                 take;
   logic                 room;
   logic                 row_push;
   tt_pkg::rsp_row_type  row;
   tt_pkg::rsp_item_type out_item;

   // The held byte is scanned when the result queue has a free row.
   assign take       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || take;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !take);

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser;
      end
   end

   tt_scan #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (take),
      .text_byte   (in_byte_ff),
      .end_of_text (in_end_ff),
      .row         (row),
      .row_push    (row_push)
   );

   tt_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (row_push),
      .row       (row),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Result beat packing.
   assign rsp_tdata = {6'b0, out_item.last_of_step, out_item.first_of_token,
                       out_item.token_byte};
   assign rsp_tuser = {out_item.token_class, out_item.byte_valid};
   assign rsp_tlast = out_item.last_of_token;

endmodule

@@ rtl/core/tt_scan.sv @@
// Scanner state and the per-byte tokenizing decision for the text tokenizer.
// Depends on tt_pkg.

module tt_scan #(
   parameter int MAX_TOKEN_LEN = tt_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output tt_pkg::rsp_row_type row,
   output logic                row_push
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LEN);

   typedef struct packed {
      tt_pkg::scan_mode_type mode;
      logic [7:0]            held_byte;
      logic                  held_valid;
      logic                  held_first;
      logic [LEN_W-1:0]      len;
   } scan_state_type;

   typedef struct packed {
      scan_state_type            st;
      tt_pkg::rsp_item_type [1:0] item;
      logic [1:0]                count;
   } work_type;

   scan_state_type state_ff;
   scan_state_type state_in;
   work_type       work;

   // Character classes.
   function automatic logic is_space(logic [7:0] b);
      return (b == tt_pkg::CHAR_SPACE) || (b == tt_pkg::CHAR_LF) ||
             (b == tt_pkg::CHAR_CR) || (b == tt_pkg::CHAR_TAB);
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= tt_pkg::CHAR_ZERO) && (b <= tt_pkg::CHAR_NINE);
   endfunction

   function automatic logic is_punct(logic [7:0] b);
      return ((b >= tt_pkg::CHAR_BANG) && (b <= tt_pkg::CHAR_SLASH)) ||
             ((b >= tt_pkg::CHAR_COLON) && (b <= tt_pkg::CHAR_AT)) ||
             ((b >= tt_pkg::CHAR_LBRACK) && (b <= tt_pkg::CHAR_GRAVE)) ||
             ((b >= tt_pkg::CHAR_LBRACE) && (b <= tt_pkg::CHAR_TILDE));
   endfunction

   function automatic logic is_cmp(logic [7:0] b);
      return (b == tt_pkg::CHAR_BANG) || (b == tt_pkg::CHAR_EQUAL) ||
             (b == tt_pkg::CHAR_LT) || (b == tt_pkg::CHAR_GT);
   endfunction

   // Token class that a scanner mode reports.
   function automatic logic [1:0] class_of(tt_pkg::scan_mode_type m);
      logic [1:0] c;
      case (m)
         tt_pkg::MODE_NUMBER: c = tt_pkg::CLASS_NUMBER;
         tt_pkg::MODE_STRING: c = tt_pkg::CLASS_STRING;
         tt_pkg::MODE_ESCAPE: c = tt_pkg::CLASS_STRING;
         tt_pkg::MODE_MINUS:  c = tt_pkg::CLASS_PUNCT;
         tt_pkg::MODE_CMP:    c = tt_pkg::CLASS_PUNCT;
         default:             c = tt_pkg::CLASS_WORD;
      endcase
      return c;
   endfunction

   // Append one result beat to the work record.
   function automatic work_type emit(work_type w_in, logic [7:0] b, logic valid,
                                     logic [1:0] cls, logic first, logic last);
      work_type w;
      w = w_in;
      if (w.count != 2'd2) begin
         w.item[w.count[0]].token_byte     = b;
         w.item[w.count[0]].byte_valid     = valid;
         w.item[w.count[0]].token_class    = cls;
         w.item[w.count[0]].first_of_token = first;
         w.item[w.count[0]].last_of_token  = last;
         w.item[w.count[0]].last_of_step   = 1'b0;
         w.count = w.count + 2'd1;
      end
      return w;
   endfunction

   // Release the held byte as the last byte of its token.
   function automatic work_type finish_held(work_type w_in);
      work_type w;
      w = w_in;
      if (w.st.held_valid) begin
         w = emit(w, w.st.held_byte, 1'b1, class_of(w.st.mode), w.st.held_first, 1'b1);
      end
      w.st.held_valid = 1'b0;
      w.st.held_first = 1'b0;
      return w;
   endfunction

   // Add a byte to the current token; cut the token at the length limit.
   function automatic work_type append(work_type w_in, logic [7:0] b);
      work_type w;
      logic     first;
      w = w_in;
      first = 1'b1;
      if (w.st.held_valid) begin
         w = emit(w, w.st.held_byte, 1'b1, class_of(w.st.mode), w.st.held_first, 1'b0);
         first = 1'b0;
      end
      w.st.held_byte  = b;
      w.st.held_valid = 1'b1;
      w.st.held_first = first;
      w.st.len        = w.st.len + LEN_W'(1);
      if (w.st.len >= LEN_LIMIT) begin
         w = finish_held(w);
         w.st.mode = (w.st.mode == tt_pkg::MODE_STRING) ? tt_pkg::MODE_SKIP
                                                        : tt_pkg::MODE_IDLE;
         w.st.len  = '0;
      end
      return w;
   endfunction

   // Begin a new token with this byte.
   function automatic work_type start(work_type w_in, logic [7:0] b);
      work_type w;
      w = w_in;
      w.st.held_valid = 1'b0;
      w.st.held_first = 1'b0;
      w.st.len        = '0;
      w.st.mode       = tt_pkg::MODE_IDLE;
      if (is_space(b)) begin
         // Whitespace is dropped.
      end else if (is_digit(b)) begin
         w.st.mode = tt_pkg::MODE_NUMBER;
         w = append(w, b);
      end else if (b == tt_pkg::CHAR_MINUS) begin
         w.st.mode       = tt_pkg::MODE_MINUS;
         w.st.held_byte  = b;
         w.st.held_valid = 1'b1;
         w.st.held_first = 1'b1;
         w.st.len        = LEN_W'(1);
      end else if (b == tt_pkg::CHAR_QUOTE) begin
         w.st.mode = tt_pkg::MODE_STRING;
      end else if (is_cmp(b)) begin
         w.st.mode       = tt_pkg::MODE_CMP;
         w.st.held_byte  = b;
         w.st.held_valid = 1'b1;
         w.st.held_first = 1'b1;
         w.st.len        = LEN_W'(1);
      end else if (is_punct(b)) begin
         w = emit(w, b, 1'b1, tt_pkg::CLASS_PUNCT, 1'b1, 1'b1);
      end else begin
         w.st.mode = tt_pkg::MODE_WORD;
         w = append(w, b);
      end
      return w;
   endfunction

   // Close the current token; an empty string still gives one beat.
   function automatic work_type end_token(work_type w_in);
      work_type w;
      w = w_in;
      if (((w.st.mode == tt_pkg::MODE_STRING) || (w.st.mode == tt_pkg::MODE_ESCAPE)) &&
          !w.st.held_valid) begin
         w = emit(w, tt_pkg::CHAR_NUL, 1'b0, tt_pkg::CLASS_STRING, 1'b1, 1'b1);
      end else if ((w.st.mode != tt_pkg::MODE_SKIP) && (w.st.mode != tt_pkg::MODE_IDLE)) begin
         w = finish_held(w);
      end
      w.st.mode       = tt_pkg::MODE_IDLE;
      w.st.held_valid = 1'b0;
      w.st.held_first = 1'b0;
      w.st.len        = '0;
      return w;
   endfunction

   // Full decision for one input byte.
   function automatic work_type step(work_type w_in, logic [7:0] b, logic eot);
      work_type w;
      w = w_in;
      if (eot || (b == tt_pkg::CHAR_NUL)) begin
         w = end_token(w);
      end else begin
         case (w.st.mode)
            tt_pkg::MODE_NUMBER: begin
               if (is_digit(b) || (b == tt_pkg::CHAR_X)) begin
                  w = append(w, b);
               end else begin
                  w = finish_held(w);
                  w = start(w, b);
               end
            end
            tt_pkg::MODE_WORD: begin
               if (is_space(b) || is_punct(b)) begin
                  w = finish_held(w);
                  w = start(w, b);
               end else begin
                  w = append(w, b);
               end
            end
            tt_pkg::MODE_STRING: begin
               if (b == tt_pkg::CHAR_QUOTE) begin
                  w = end_token(w);
               end else if (b == tt_pkg::CHAR_BSLASH) begin
                  w.st.mode = tt_pkg::MODE_ESCAPE;
               end else begin
                  w = append(w, b);
               end
            end
            tt_pkg::MODE_ESCAPE: begin
               // A second backslash keeps the escape open.
               if (b != tt_pkg::CHAR_BSLASH) begin
                  w.st.mode = tt_pkg::MODE_STRING;
                  if (b == tt_pkg::CHAR_N) begin
                     w = append(w, tt_pkg::CHAR_LF);
                  end else if (b == tt_pkg::CHAR_T) begin
                     w = append(w, tt_pkg::CHAR_TAB);
                  end else if (b == tt_pkg::CHAR_R) begin
                     w = append(w, tt_pkg::CHAR_CR);
                  end else begin
                     w = append(w, b);
                  end
               end
            end
            tt_pkg::MODE_MINUS: begin
               if (is_digit(b)) begin
                  w.st.mode = tt_pkg::MODE_NUMBER;
                  w = append(w, b);
               end else begin
                  w = finish_held(w);
                  w = start(w, b);
               end
            end
            tt_pkg::MODE_CMP: begin
               if (b == tt_pkg::CHAR_EQUAL) begin
                  w = emit(w, w.st.held_byte, 1'b1, tt_pkg::CLASS_PUNCT, 1'b1, 1'b0);
                  w = emit(w, b, 1'b1, tt_pkg::CLASS_PUNCT, 1'b0, 1'b1);
                  w.st.held_valid = 1'b0;
                  w.st.mode       = tt_pkg::MODE_IDLE;
                  w.st.len        = '0;
               end else begin
                  w = finish_held(w);
                  w = start(w, b);
               end
            end
            tt_pkg::MODE_SKIP: begin
               // The byte after a cut string stands in for its closing quote.
               w.st.mode       = tt_pkg::MODE_IDLE;
               w.st.held_valid = 1'b0;
               w.st.len        = '0;
            end
            default: begin
               w = start(w, b);
            end
         endcase
      end
      return w;
   endfunction

   // Evaluate the current byte against the stored state.
   always_comb begin
      work.st    = state_ff;
      work.item  = '0;
      work.count = '0;
      work       = step(work, text_byte, end_of_text);
      if (work.count == 2'd2) begin
         work.item[1].last_of_step = 1'b1;
      end else if (work.count == 2'd1) begin
         work.item[0].last_of_step = 1'b1;
      end
   end

   assign row.item = work.item;
   assign row.two  = (work.count == 2'd2);
   assign row_push = step_en && (work.count != 2'd0);
   assign state_in = step_en ? work.st : state_ff;

   // Scanner state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= tt_pkg::MODE_IDLE;
         state_ff.held_byte  <= '0;
         state_ff.held_valid <= 1'b0;
         state_ff.held_first <= 1'b0;
         state_ff.len        <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/tt_outq.sv @@
// Two-row text tokenizer result queue: a row holds the one or two beats of one
// input byte, sent one beat per cycle while out_ready is high. Depends on tt_pkg.

module tt_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tt_pkg::rsp_row_type  row,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tt_pkg::rsp_item_type out_item
);

   tt_pkg::rsp_row_type head_ff, head_in;
   tt_pkg::rsp_row_type tail_ff, tail_in;
   logic                head_valid_ff, head_valid_in;
   logic                tail_valid_ff, tail_valid_in;
   logic                sel_ff, sel_in;
   logic                beat_done;
   logic                pop;
   logic                shift_valid;

   // Room for a new row whenever the tail slot is free.
   assign room      = !tail_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_item  = sel_ff ? head_ff.item[1] : head_ff.item[0];
   assign beat_done = head_valid_ff && out_ready;
   assign pop       = beat_done && (sel_ff || !head_ff.two);

   // Advance within the head row, retire it, then place the pushed row.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      sel_in        = sel_ff;
      shift_valid   = head_valid_ff;
      if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         shift_valid   = tail_valid_ff;
         tail_valid_in = 1'b0;
         sel_in        = 1'b0;
      end else if (beat_done) begin
         sel_in = 1'b1;
      end
      if (push) begin
         if (!shift_valid) begin
            head_in       = row;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = row;
            tail_valid_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
         sel_ff        <= sel_in;
      end
   end

   // Row payload.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
